// ===== sv/oft_pkg.sv =====
// Shared types and constants for the open-file share table.
`default_nettype none
package oft_pkg;

    localparam int DEF_TABLE_SLOTS = 16;
    localparam int DEF_INODE_BITS  = 16;
    localparam int ID_IN_W         = 16;
    localparam int HANDLE_W        = 4;
    localparam int USERS_W         = 8;
    localparam logic [USERS_W-1:0] USERS_MAX = 8'hFF;

    localparam logic REQ_OPEN  = 1'b0;
    localparam logic REQ_CLOSE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_DIR_WRITE  = 3'd1,
        ST_WRITER     = 3'd2,
        ST_BUSY       = 3'd3,
        ST_FULL       = 3'd4,
        ST_COUNT_MAX  = 3'd5,
        ST_CLOSE_IDLE = 3'd6
    } t_status;

    typedef struct packed {
        logic match;
        logic empty;
        logic idle;
    } t_slot_flags;

endpackage
`default_nettype wire

// ===== sv/oft_slot_cmp.sv =====
// Shared slot compare unit: classifies one slot entry against the request.
`default_nettype none
module oft_slot_cmp
    import oft_pkg::*;
#(
    parameter int INODE_BITS = DEF_INODE_BITS
) (
    input  wire logic                  i_entry_valid,
    input  wire logic [INODE_BITS-1:0] i_entry_inode,
    input  wire logic                  i_entry_dir,
    input  wire logic [USERS_W-1:0]    i_entry_users,
    input  wire logic [INODE_BITS-1:0] i_req_inode,
    input  wire logic                  i_req_dir,
    output t_slot_flags                o_flags
);

    always_comb begin
        o_flags.match = i_entry_valid && (i_entry_inode == i_req_inode)
                        && (i_entry_dir == i_req_dir);
        o_flags.empty = !i_entry_valid;
        o_flags.idle  = i_entry_valid && (i_entry_users == '0);
    end

endmodule
`default_nettype wire

// ===== sv/open_file_share_table.sv =====
// Top level of the open-file share table: sequencer, slot memory and result register.
`default_nettype none
// An open request scans every slot through one compare unit, one slot per
// cycle from the single read port of the slot memory, then decides and writes
// back in S_DECIDE. A close reads one slot and answers from S_CLOSE; a refused
// directory write answers straight from S_IDLE. Each result appears on o_status
// and o_handle for one cycle with o_done high; the receiver cannot stall, so a
// result must be taken when it is shown. busy is low in the o_done cycle.
module open_file_share_table
    import oft_pkg::*;
#(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
    parameter int INODE_BITS  = DEF_INODE_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                i_req_type,
    input  wire logic [ID_IN_W-1:0]  i_inode_id,
    input  wire logic                i_is_directory,
    input  wire logic                i_read_mode,
    input  wire logic [HANDLE_W-1:0] i_close_handle,
    output logic                     o_done,
    output logic [2:0]               o_status,
    output logic [HANDLE_W-1:0]      o_handle
);

    localparam int IDX_W   = $clog2(TABLE_SLOTS);
    localparam int ENTRY_W = INODE_BITS + 2 + USERS_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_CLOSE
    } t_state;

    function automatic logic [HANDLE_W-1:0] f_handle(input logic [IDX_W-1:0] idx);
        logic [IDX_W+HANDLE_W-1:0] ext;
        ext = {{HANDLE_W{1'b0}}, idx};
        return ext[HANDLE_W-1:0];
    endfunction

    t_state                  r_state, n_state;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [INODE_BITS-1:0]   r_id, n_id;
    logic                    r_dir, n_dir;
    logic                    r_rd, n_rd;
    logic                    r_close_bad, n_close_bad;
    logic                    r_m_found, n_m_found;
    logic [IDX_W-1:0]        r_m_idx, n_m_idx;
    logic [USERS_W-1:0]      r_m_users, n_m_users;
    logic                    r_m_mode, n_m_mode;
    logic                    r_e_found, n_e_found;
    logic [IDX_W-1:0]        r_e_idx, n_e_idx;
    logic                    r_i_found, n_i_found;
    logic [IDX_W-1:0]        r_i_idx, n_i_idx;
    logic                    r_done, n_done;
    t_status                 r_status, n_status;
    logic [HANDLE_W-1:0]     r_handle, n_handle;
    logic [TABLE_SLOTS-1:0]  r_valid, n_valid;

    logic [ENTRY_W-1:0]      r_mem [TABLE_SLOTS];
    logic [ENTRY_W-1:0]      r_rd_data;
    logic [IDX_W-1:0]        rd_addr;
    logic                    w_we;
    logic [IDX_W-1:0]        w_addr;
    logic [ENTRY_W-1:0]      w_data;

    logic [INODE_BITS+ID_IN_W-1:0] id_ext;
    logic [INODE_BITS-1:0]   req_id;
    logic [IDX_W+HANDLE_W-1:0] ch_ext;
    logic                    ch_bad;
    logic [IDX_W-1:0]        ch_idx;
    logic                    accept;

    logic [USERS_W-1:0]      e_users;
    logic                    e_mode;
    logic                    e_dir;
    logic [INODE_BITS-1:0]   e_inode;
    t_slot_flags             flags;

    assign id_ext = {{INODE_BITS{1'b0}}, i_inode_id};
    assign req_id = id_ext[INODE_BITS-1:0];
    assign ch_ext = {{IDX_W{1'b0}}, i_close_handle};
    assign ch_bad = int'(i_close_handle) >= TABLE_SLOTS;
    assign ch_idx = ch_bad ? '0 : ch_ext[IDX_W-1:0];
    assign accept = start && !busy;

    assign e_users = r_rd_data[USERS_W-1:0];
    assign e_mode  = r_rd_data[USERS_W];
    assign e_dir   = r_rd_data[USERS_W+1];
    assign e_inode = r_rd_data[ENTRY_W-1:USERS_W+2];

    oft_slot_cmp #(
        .INODE_BITS(INODE_BITS)
    ) u_cmp (
        .i_entry_valid(r_valid[r_idx]),
        .i_entry_inode(e_inode),
        .i_entry_dir  (e_dir),
        .i_entry_users(e_users),
        .i_req_inode  (r_id),
        .i_req_dir    (r_dir),
        .o_flags      (flags)
    );

    always_comb begin
        case (r_state)
            S_IDLE:  rd_addr = (i_req_type == REQ_CLOSE) ? ch_idx : '0;
            S_SCAN:  rd_addr = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            default: rd_addr = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        if (w_we) begin
            r_mem[w_addr] <= w_data;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_id        = r_id;
        n_dir       = r_dir;
        n_rd        = r_rd;
        n_close_bad = r_close_bad;
        n_m_found   = r_m_found;
        n_m_idx     = r_m_idx;
        n_m_users   = r_m_users;
        n_m_mode    = r_m_mode;
        n_e_found   = r_e_found;
        n_e_idx     = r_e_idx;
        n_i_found   = r_i_found;
        n_i_idx     = r_i_idx;
        n_done      = 1'b0;
        n_status    = r_status;
        n_handle    = r_handle;
        n_valid     = r_valid;
        w_we        = 1'b0;
        w_addr      = r_idx;
        w_data      = {r_id, r_dir, r_rd, USERS_W'(1)};
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_id        = req_id;
                    n_dir       = i_is_directory;
                    n_rd        = i_read_mode;
                    n_close_bad = ch_bad;
                    n_m_found   = 1'b0;
                    n_e_found   = 1'b0;
                    n_i_found   = 1'b0;
                    if (i_req_type == REQ_CLOSE) begin
                        n_idx   = ch_idx;
                        n_state = S_CLOSE;
                    end else if (!i_read_mode && i_is_directory) begin
                        n_done   = 1'b1;
                        n_status = ST_DIR_WRITE;
                        n_handle = '0;
                    end else begin
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (flags.match && !r_m_found) begin
                    n_m_found = 1'b1;
                    n_m_idx   = r_idx;
                    n_m_users = e_users;
                    n_m_mode  = e_mode;
                end
                if (flags.empty && !r_e_found) begin
                    n_e_found = 1'b1;
                    n_e_idx   = r_idx;
                end
                if (flags.idle && !r_i_found) begin
                    n_i_found = 1'b1;
                    n_i_idx   = r_idx;
                end
                if (r_idx == LAST_IDX) begin
                    n_state = S_DECIDE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DECIDE: begin
                n_done   = 1'b1;
                n_state  = S_IDLE;
                n_handle = '0;
                if (r_m_found) begin
                    w_addr = r_m_idx;
                    if (r_m_users == '0) begin
                        w_we     = 1'b1;
                        n_status = ST_OK;
                        n_handle = f_handle(r_m_idx);
                    end else if (r_rd && r_m_mode) begin
                        if (r_m_users == USERS_MAX) begin
                            n_status = ST_COUNT_MAX;
                        end else begin
                            w_we     = 1'b1;
                            w_data   = {r_id, r_dir, r_rd, r_m_users + 1'b1};
                            n_status = ST_OK;
                            n_handle = f_handle(r_m_idx);
                        end
                    end else if (!r_m_mode) begin
                        n_status = ST_WRITER;
                    end else begin
                        n_status = ST_BUSY;
                    end
                end else if (r_e_found) begin
                    w_we             = 1'b1;
                    w_addr           = r_e_idx;
                    n_valid[r_e_idx] = 1'b1;
                    n_status         = ST_OK;
                    n_handle         = f_handle(r_e_idx);
                end else if (r_i_found) begin
                    w_we     = 1'b1;
                    w_addr   = r_i_idx;
                    n_status = ST_OK;
                    n_handle = f_handle(r_i_idx);
                end else begin
                    n_status = ST_FULL;
                end
            end
            S_CLOSE: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                if (r_close_bad || flags.empty || !flags.idle && e_users == '0) begin
                    n_status = ST_CLOSE_IDLE;
                    n_handle = '0;
                end else if (flags.idle) begin
                    n_status = ST_CLOSE_IDLE;
                    n_handle = '0;
                end else begin
                    w_we     = 1'b1;
                    w_addr   = r_idx;
                    w_data   = {e_inode, e_dir, e_mode, e_users - 1'b1};
                    n_status = ST_OK;
                    n_handle = f_handle(r_idx);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_valid <= n_valid;
        end
        r_idx       <= n_idx;
        r_id        <= n_id;
        r_dir       <= n_dir;
        r_rd        <= n_rd;
        r_close_bad <= n_close_bad;
        r_m_found   <= n_m_found;
        r_m_idx     <= n_m_idx;
        r_m_users   <= n_m_users;
        r_m_mode    <= n_m_mode;
        r_e_found   <= n_e_found;
        r_e_idx     <= n_e_idx;
        r_i_found   <= n_i_found;
        r_i_idx     <= n_i_idx;
        r_status    <= n_status;
        r_handle    <= n_handle;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_handle = r_handle;

    // busy only rises on an accepted beat
    a_busy_from_start: assert property (@(posedge i_clk)
        i_rst_n && $past(i_rst_n) && $rose(busy) |-> $past(start))
        else $error("busy rose without start");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    a_handle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status != ST_OK) |-> (o_handle == '0))
        else $error("nonzero handle on a refused request");

    // slots never return to empty
    a_valid_grows: assert property (@(posedge i_clk)
        i_rst_n && $past(i_rst_n) |-> $countones(r_valid) >= $past($countones(r_valid)))
        else $error("slot valid bit cleared");

endmodule
`default_nettype wire
